FILE: hw/rtl/sfae_pkg.sv
// Shared types, constants and helpers for the SLCAN frame line encoder.
// Has no dependencies. Every other RTL file imports it.
`default_nettype none

package sfae_pkg;

   localparam int IdentWidth   = 29;
   localparam int LengthWidth  = 4;
   localparam int PayloadWidth = 64;
   localparam int StampWidth   = 16;
   localparam int CharWidth    = 7;
   localparam int NibbleWidth  = 4;
   localparam int CountWidth   = 5;

   // The identifier shifter holds eight nibbles.
   localparam int IdentShiftWidth = 32;

   localparam logic [CharWidth-1:0] CHAR_CR       = 7'h0D;
   localparam logic [CharWidth-1:0] CHAR_ZERO     = 7'h30;
   localparam logic [CharWidth-1:0] CHAR_UPPER_A  = 7'h41;
   localparam logic [CharWidth-1:0] CHAR_UPPER_R  = 7'h52;
   localparam logic [CharWidth-1:0] CHAR_UPPER_T  = 7'h54;
   localparam logic [CharWidth-1:0] CHAR_LOWER_R  = 7'h72;
   localparam logic [CharWidth-1:0] CHAR_LOWER_T  = 7'h74;

   localparam logic [LengthWidth-1:0] MaxDataBytes = 4'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TYPE,
      ST_IDENT,
      ST_LENGTH,
      ST_DATA,
      ST_STAMP,
      ST_END
   } state_type;

   typedef struct packed {
      logic load;
      logic shift_ident;
      logic shift_data;
      logic shift_stamp;
   } ctrl_type;

   function automatic logic [CharWidth-1:0] hex_char(input logic [NibbleWidth-1:0] nibble);
      logic [CharWidth-1:0] wide;
      wide = {{(CharWidth-NibbleWidth){1'b0}}, nibble};
      if (nibble > 4'd9) begin
         hex_char = CHAR_UPPER_A + wide - 7'd10;
      end else begin
         hex_char = CHAR_ZERO + wide;
      end
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sfae_nibble_shift.sv
// Nibble-wide shift register: loads a word, then presents one hex digit per shift.
// Depends on sfae_pkg.
`default_nettype none

module sfae_nibble_shift #(
   parameter int Width = 32
) (
   input  wire logic                            clock,
   input  wire logic                            load,
   input  wire logic [Width-1:0]                load_value,
   input  wire logic                            shift,
   output logic [sfae_pkg::NibbleWidth-1:0]     nibble
);
   import sfae_pkg::*;

   logic [Width-1:0] data_ff;
   logic [Width-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = load_value;
      end else if (shift) begin
         data_in = {data_ff[Width-NibbleWidth-1:0], {NibbleWidth{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign nibble = data_ff[Width-1 -: NibbleWidth];

endmodule

`default_nettype wire

FILE: hw/rtl/sfae_sequencer.sv
// Line sequencer: walks the fields of one frame and picks the character to emit.
// Depends on sfae_pkg; drives the nibble shifters through a control struct.
`default_nettype none

module sfae_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              is_extended,
   input  wire logic                              is_remote,
   input  wire logic [sfae_pkg::LengthWidth-1:0]  length_code,
   input  wire logic                              timestamp_enable,
   input  wire logic                              advance,
   input  wire logic [sfae_pkg::NibbleWidth-1:0]  ident_nibble,
   input  wire logic [sfae_pkg::NibbleWidth-1:0]  data_nibble,
   input  wire logic [sfae_pkg::NibbleWidth-1:0]  stamp_nibble,
   output logic                                   busy,
   output logic                                   char_valid,
   output logic [sfae_pkg::CharWidth-1:0]         char_value,
   output logic                                   char_last,
   output sfae_pkg::ctrl_type                     ctrl
);
   import sfae_pkg::*;

   state_type              state_ff, state_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   ext_ff, ext_in;
   logic                   rtr_ff, rtr_in;
   logic [LengthWidth-1:0] dlc_ff, dlc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      ext_ff   <= ext_in;
      rtr_ff   <= rtr_in;
      dlc_ff   <= dlc_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ext_in     = ext_ff;
      rtr_in     = rtr_ff;
      dlc_in     = dlc_ff;
      busy       = 1'b1;
      char_valid = 1'b1;
      char_value = CHAR_CR;
      char_last  = 1'b0;
      ctrl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            char_valid = 1'b0;
            if (req_valid) begin
               ctrl.load = 1'b1;
               ext_in    = is_extended;
               rtr_in    = is_remote;
               dlc_in    = length_code;
               state_in  = ST_TYPE;
            end
         end
         ST_TYPE: begin
            if (ext_ff) begin
               char_value = rtr_ff ? CHAR_UPPER_R : CHAR_UPPER_T;
            end else begin
               char_value = rtr_ff ? CHAR_LOWER_R : CHAR_LOWER_T;
            end
            if (advance) begin
               count_in = ext_ff ? 5'd7 : 5'd2;
               state_in = ST_IDENT;
            end
         end
         ST_IDENT: begin
            char_value = hex_char(ident_nibble);
            if (advance) begin
               ctrl.shift_ident = 1'b1;
               count_in         = count_ff - 5'd1;
               if (count_ff == '0) begin
                  state_in = ST_LENGTH;
               end
            end
         end
         ST_LENGTH: begin
            char_value = hex_char(dlc_ff);
            if (advance) begin
               priority if (!rtr_ff && dlc_ff != '0) begin
                  count_in = (dlc_ff > MaxDataBytes) ? 5'd15 : ({dlc_ff, 1'b0} - 5'd1);
                  state_in = ST_DATA;
               end else if (timestamp_enable) begin
                  count_in = 5'd3;
                  state_in = ST_STAMP;
               end else begin
                  state_in = ST_END;
               end
            end
         end
         ST_DATA: begin
            char_value = hex_char(data_nibble);
            if (advance) begin
               ctrl.shift_data = 1'b1;
               count_in        = count_ff - 5'd1;
               if (count_ff == '0) begin
                  count_in = 5'd3;
                  state_in = timestamp_enable ? ST_STAMP : ST_END;
               end
            end
         end
         ST_STAMP: begin
            char_value = hex_char(stamp_nibble);
            if (advance) begin
               ctrl.shift_stamp = 1'b1;
               count_in         = count_ff - 5'd1;
               if (count_ff == '0) begin
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            char_value = CHAR_CR;
            char_last  = 1'b1;
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/slcan_frame_ascii_encoder.sv
// SLCAN frame line encoder: one CAN frame in, its ASCII line out one character per item.
// A taken frame sets the sequencer to its type state, whose letter goes through the output
// register to rsp_valid. A line has L characters (6 to 31); frames are taken only in idle.
// Unless stalled, the sequencer walks one hex digit per cycle out of the nibble shifters.
// Reset clears the sequencer, the output valid flag and the timestamp enable.
// Depends on sfae_pkg, sfae_nibble_shift and sfae_sequencer.
`default_nettype none

module slcan_frame_ascii_encoder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_is_extended,
   input  wire logic                               req_is_remote,
   input  wire logic [sfae_pkg::IdentWidth-1:0]    req_identifier,
   input  wire logic [sfae_pkg::LengthWidth-1:0]   req_length_code,
   input  wire logic [sfae_pkg::PayloadWidth-1:0]  req_payload,
   input  wire logic [sfae_pkg::StampWidth-1:0]    req_stamp,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [sfae_pkg::CharWidth-1:0]          rsp_ascii_char,
   output logic                                    rsp_last_char,
   input  wire logic                               csr_write_enable,
   input  wire logic                               csr_write_data
);
   import sfae_pkg::*;

   logic                       ts_enable_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [CharWidth-1:0]       out_char_ff, out_char_in;
   logic                       out_last_ff, out_last_in;

   logic                       busy;
   logic                       char_valid;
   logic [CharWidth-1:0]       char_value;
   logic                       char_last;
   logic                       advance;
   ctrl_type                   ctrl;
   logic [NibbleWidth-1:0]     ident_nibble;
   logic [NibbleWidth-1:0]     data_nibble;
   logic [NibbleWidth-1:0]     stamp_nibble;
   logic [IdentShiftWidth-1:0] ident_load;

   // Standard identifiers are left aligned so their top digit is shifted out first.
   assign ident_load = req_is_extended
      ? {{(IdentShiftWidth-IdentWidth){1'b0}}, req_identifier}
      : {req_identifier[11:0], {(IdentShiftWidth-12){1'b0}}};

   assign advance   = char_valid && (!out_valid_ff || !rsp_stall);
   assign req_stall = busy;

   sfae_sequencer u_sequencer (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .is_extended      (req_is_extended),
      .is_remote        (req_is_remote),
      .length_code      (req_length_code),
      .timestamp_enable (ts_enable_ff),
      .advance          (advance),
      .ident_nibble     (ident_nibble),
      .data_nibble      (data_nibble),
      .stamp_nibble     (stamp_nibble),
      .busy             (busy),
      .char_valid       (char_valid),
      .char_value       (char_value),
      .char_last        (char_last),
      .ctrl             (ctrl)
   );

   sfae_nibble_shift #(.Width(IdentShiftWidth)) u_ident_shift (
      .clock      (clock),
      .load       (ctrl.load),
      .load_value (ident_load),
      .shift      (ctrl.shift_ident),
      .nibble     (ident_nibble)
   );

   sfae_nibble_shift #(.Width(PayloadWidth)) u_data_shift (
      .clock      (clock),
      .load       (ctrl.load),
      .load_value (req_payload),
      .shift      (ctrl.shift_data),
      .nibble     (data_nibble)
   );

   sfae_nibble_shift #(.Width(StampWidth)) u_stamp_shift (
      .clock      (clock),
      .load       (ctrl.load),
      .load_value (req_stamp),
      .shift      (ctrl.shift_stamp),
      .nibble     (stamp_nibble)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_char_in  = char_value;
         out_last_in  = char_last;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         ts_enable_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            ts_enable_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ascii_char = out_char_ff;
   assign rsp_last_char  = out_last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sfae_checker.sv
// Port-level checker for the SLCAN frame line encoder, bound to the top level.
// Depends on sfae_pkg.
`default_nettype none

module sfae_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_stall,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  wire logic [sfae_pkg::CharWidth-1:0]     rsp_ascii_char,
   input  wire logic                               rsp_last_char
);
   import sfae_pkg::*;

   // A stalled item stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled item was dropped");

   // Once a frame is taken, no second frame is taken before its line starts.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("frame taken while the previous one is in progress");

   // The flagged last item is always the carriage return.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_ascii_char == CHAR_CR)
      else $error("last item is not a carriage return");

   // A carriage return appears only as the flagged last item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |-> rsp_ascii_char != CHAR_CR)
      else $error("carriage return inside a line");

endmodule

bind slcan_frame_ascii_encoder sfae_checker u_sfae_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_ascii_char (rsp_ascii_char),
   .rsp_last_char  (rsp_last_char)
);

`default_nettype wire

FILE: dv/slcan_frame_ascii_encoder_tb.sv
// Self-checking testbench for slcan_frame_ascii_encoder: CAN frames go in, and every
// character of the ASCII line that comes out is checked against an in-bench predictor.
// Depends on sfae_pkg and the RTL of the encoder only.
`timescale 1ns / 1ps

module slcan_frame_ascii_encoder_tb;
   import sfae_pkg::*;

   typedef struct {
      logic                    is_extended;
      logic                    is_remote;
      logic [IdentWidth-1:0]   identifier;
      logic [LengthWidth-1:0]  length_code;
      logic [PayloadWidth-1:0] payload;
      logic [StampWidth-1:0]   stamp;
   } can_frame_type;

   typedef struct {
      logic [CharWidth-1:0] ascii;
      logic                 last;
   } line_char_type;

   localparam int LongHold = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_is_extended = 1'b0;
   logic                    req_is_remote = 1'b0;
   logic [IdentWidth-1:0]   req_identifier = '0;
   logic [LengthWidth-1:0]  req_length_code = '0;
   logic [PayloadWidth-1:0] req_payload = '0;
   logic [StampWidth-1:0]   req_stamp = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [CharWidth-1:0]    rsp_ascii_char;
   logic                    rsp_last_char;
   logic                    csr_write_enable = 1'b0;
   logic                    csr_write_data = 1'b0;

   can_frame_type  pending_frames[$];
   line_char_type  line_chars[$];
   can_frame_type  cur_frame;
   int         frames_queued = 0;
   int         frames_accepted = 0;
   int         mismatches = 0;
   int         send_gap = 0;
   int         stall_left = 0;
   logic       stamp_on = 1'b0;
   logic       idle_on = 1'b1;
   logic       hold_request = 1'b0;
   logic       hold_seen = 1'b0;

   always #5 clock = ~clock;

   slcan_frame_ascii_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_is_extended  (req_is_extended),
      .req_is_remote    (req_is_remote),
      .req_identifier   (req_identifier),
      .req_length_code  (req_length_code),
      .req_payload      (req_payload),
      .req_stamp        (req_stamp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ascii_char   (rsp_ascii_char),
      .rsp_last_char    (rsp_last_char),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CharWidth-1:0] nibble_char(logic [NibbleWidth-1:0] n);
      if (n < 4'd10) return CHAR_ZERO + CharWidth'(n);
      return CHAR_UPPER_A + CharWidth'(n - 4'd10);
   endfunction

   task automatic push_char(logic [CharWidth-1:0] ch, logic last);
      line_char_type c;
      c.ascii = ch;
      c.last = last;
      line_chars.push_back(c);
   endtask

   // Appends the whole ASCII line that one frame produces.
   task automatic predict_line(can_frame_type f);
      logic [31:0]            id_wide;
      logic [NibbleWidth-1:0] nib;
      int                     ndig;
      int                     nbytes;
      if (f.is_extended) push_char(f.is_remote ? CHAR_UPPER_R : CHAR_UPPER_T, 1'b0);
      else push_char(f.is_remote ? CHAR_LOWER_R : CHAR_LOWER_T, 1'b0);
      id_wide = {3'b000, f.identifier};
      ndig = f.is_extended ? 8 : 3;
      for (int i = 0; i < ndig; i++) begin
         nib = NibbleWidth'(id_wide >> (4 * (ndig - 1 - i)));
         push_char(nibble_char(nib), 1'b0);
      end
      push_char(nibble_char(f.length_code), 1'b0);
      if (!f.is_remote && f.length_code != 0) begin
         nbytes = (f.length_code > MaxDataBytes) ? int'(MaxDataBytes) : int'(f.length_code);
         for (int i = 0; i < 2 * nbytes; i++) begin
            nib = NibbleWidth'(f.payload >> (60 - 4 * i));
            push_char(nibble_char(nib), 1'b0);
         end
      end
      if (stamp_on) begin
         for (int i = 0; i < 4; i++) begin
            nib = NibbleWidth'(f.stamp >> (12 - 4 * i));
            push_char(nibble_char(nib), 1'b0);
         end
      end
      push_char(CHAR_CR, 1'b1);
   endtask

   task automatic add_frame(logic ext, logic rtr, logic [IdentWidth-1:0] id,
                            logic [LengthWidth-1:0] dlc, logic [PayloadWidth-1:0] data,
                            logic [StampWidth-1:0] ts);
      can_frame_type f;
      f.is_extended = ext;
      f.is_remote = rtr;
      f.identifier = id;
      f.length_code = dlc;
      f.payload = data;
      f.stamp = ts;
      pending_frames.push_back(f);
      frames_queued++;
   endtask

   task automatic add_random(int count);
      logic [IdentWidth-1:0] id;
      int                    sel;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 5);
         case (sel)
            3: id = '0;
            4: id = '1;
            5: id = IdentWidth'($urandom_range(0, 15));
            default: id = IdentWidth'($urandom);
         endcase
         add_frame(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, id,
                   ($urandom_range(0, 2) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8)),
                   {$urandom, $urandom}, 16'($urandom));
      end
   endtask

   task automatic add_directed();
      add_frame(1'b0, 1'b0, 29'h0, 4'd0, 64'h0, 16'h0000);
      add_frame(1'b0, 1'b0, 29'h7FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
      add_frame(1'b0, 1'b0, 29'h1FFF_FFFF, 4'd1, 64'h0123_4567_89AB_CDEF, 16'h0F0F);
      add_frame(1'b1, 1'b0, 29'h0, 4'd4, 64'hFEDC_BA98_7654_3210, 16'hA5A5);
      add_frame(1'b1, 1'b0, 29'h1FFF_FFFF, 4'd8, 64'h8000_0000_0000_0001, 16'h8001);
      add_frame(1'b0, 1'b1, 29'h123, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234);
      add_frame(1'b0, 1'b1, 29'h456, 4'd5, 64'h1111_2222_3333_4444, 16'h5678);
      add_frame(1'b1, 1'b1, 29'h1ABC_DEF0, 4'd15, 64'hFFFF_0000_FFFF_0000, 16'h9ABC);
      add_frame(1'b0, 1'b0, 29'h5A5, 4'd9, 64'hDEAD_BEEF_CAFE_F00D, 16'hDEF0);
      add_frame(1'b1, 1'b0, 29'h0ABC_DEF1, 4'd15, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
      add_frame(1'b0, 1'b0, 29'h3A5, 4'd3, 64'h5555_5555_5555_5555, 16'hAAAA);
      add_frame(1'b1, 1'b0, 29'h1234_5678, 4'd12, 64'h0F1E_2D3C_4B5A_6978, 16'hFEDC);
   endtask

   task automatic wait_lines_done();
      while (frames_accepted != frames_queued || line_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_stamp_enable(logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      stamp_on = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   always @(posedge clock) begin : frame_driver
      logic offering;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         offering = req_valid;
         if (req_valid && !req_stall) begin
            predict_line(cur_frame);
            frames_accepted++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_frames.size() != 0) begin
               cur_frame = pending_frames.pop_front();
               req_is_extended <= cur_frame.is_extended;
               req_is_remote <= cur_frame.is_remote;
               req_identifier <= cur_frame.identifier;
               req_length_code <= cur_frame.length_code;
               req_payload <= cur_frame.payload;
               req_stamp <= cur_frame.stamp;
               req_valid <= 1'b1;
               send_gap = idle_on ? next_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : line_monitor
      line_char_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (line_chars.size() == 0) begin
               $error("unexpected item: ascii_char %h last_char %b",
                      rsp_ascii_char, rsp_last_char);
               mismatches++;
            end else begin
               want = line_chars.pop_front();
               if (rsp_ascii_char !== want.ascii) begin
                  $error("ascii_char: expected %h, got %h", want.ascii, rsp_ascii_char);
                  mismatches++;
               end
               if (rsp_last_char !== want.last) begin
                  $error("last_char: expected %b, got %b", want.last, rsp_last_char);
                  mismatches++;
               end
            end
         end
         if (hold_request != hold_seen) begin
            hold_seen = hold_request;
            stall_left = LongHold;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_on ? next_gap() : 0;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("[slcan_frame_ascii_encoder] ERROR");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_stamp_enable(1'b0);
      add_directed();
      wait_lines_done();

      write_stamp_enable(1'b1);
      add_directed();
      wait_lines_done();

      add_random(100);
      wait_lines_done();

      // Back-to-back frames and an always-ready receiver.
      write_stamp_enable(1'b0);
      idle_on = 1'b0;
      add_random(60);
      wait_lines_done();

      // The receiver holds off for a long stretch so that the encoder backs up.
      idle_on = 1'b1;
      add_random(30);
      hold_request = ~hold_request;
      wait_lines_done();

      write_stamp_enable(1'b1);
      add_random(30);
      wait_lines_done();
      add_random(30);
      wait_lines_done();

      repeat (40) @(posedge clock);
      if (line_chars.size() != 0) begin
         $error("%0d expected items never arrived", line_chars.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("[slcan_frame_ascii_encoder] OK");
      end else begin
         $display("[slcan_frame_ascii_encoder] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/sfae_pkg.sv
hw/rtl/sfae_nibble_shift.sv
hw/rtl/sfae_sequencer.sv
hw/rtl/slcan_frame_ascii_encoder.sv
hw/rtl/sfae_checker.sv
dv/slcan_frame_ascii_encoder_tb.sv
